// ----- src/tlv_pkg.sv -----
package tlv_pkg;

  localparam int PAYLOAD_BYTES = 512;
  localparam int ADDR_W = $clog2(PAYLOAD_BYTES);
  localparam int PTR_W = ADDR_W + 1;
  localparam int SUM_W = PTR_W + 1;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [15:0] BLANK_KEY = 16'hFFFF;
  localparam logic [7:0] ERASED_BYTE = 8'hFF;
  localparam logic [3:0] HDR_LEN = 4'd4;

  // Request modes
  localparam logic [3:0] MODE_GET_U32 = 4'd0;
  localparam logic [3:0] MODE_GET_BOOL = 4'd1;
  localparam logic [3:0] MODE_SET_U32 = 4'd2;
  localparam logic [3:0] MODE_SET_BOOL = 4'd3;
  localparam logic [3:0] MODE_REMOVE = 4'd4;
  localparam logic [3:0] MODE_FORMAT = 4'd5;
  localparam logic [3:0] MODE_LOAD_BYTE = 4'd6;
  localparam logic [3:0] MODE_VERIFY = 4'd7;
  localparam logic [3:0] MODE_READ_BYTE = 4'd8;

  // Result status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_WRONG_TYPE = 3'd3;
  localparam logic [2:0] ST_NO_SPACE = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_END_KEY = 2'd0;
  localparam logic [1:0] CFG_TYPE_WORD = 2'd1;
  localparam logic [1:0] CFG_TYPE_BYTE = 2'd2;

  typedef struct packed {
    logic [3:0] mode;
    logic [15:0] key;
    logic [31:0] value;
    logic [8:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [31:0] value_out;
    logic [31:0] crc_out;
    logic store_valid;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CAP,
    S_SCAN_EVAL,
    S_APP_END,
    S_WR_REC,
    S_DATA_RD,
    S_DATA_CAP,
    S_MV_RD,
    S_MV_WR,
    S_FILL,
    S_CRC,
    S_CRC_FIN,
    S_BYTE_RD,
    S_BYTE_CAP,
    S_DONE
  } state_t;

  // Fold one byte into a reflected CRC-32
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'h0);
    end
    return x;
  endfunction

endpackage

// ----- src/tlv_record_store_top.sv -----
// Channel   Direction  Payload          Handshake
// in        input      tlv_pkg::req_t   in_valid / in_stall
// out       output     tlv_pkg::rsp_t   out_valid / out_stall
// cfg       input      16-bit data      cfg_wr_en / cfg_index
//
// One request at a time; a byte memory access per cycle sets the pace.
// Record scans read the four header bytes of each record, capturing each read, and then
// evaluate the record; compaction reads and then writes each moved byte; fill and record
// write store a byte at a time; CRC reads every byte of the store.
// Reset is synchronous; it clears control state and valid flags and sets config defaults.
// A result waiting under out_stall holds the block before it takes a request.
module tlv_record_store_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tlv_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tlv_pkg::rsp_t out_data,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_wr_data
);

  tlv_pkg::state_t state, state_next;

  logic [15:0] end_key;
  logic [7:0]  type_word;
  logic [7:0]  type_byte;
  logic        valid_flag;

  logic [3:0]  mode_q;
  logic [15:0] key_q;
  logic [31:0] value_q;
  logic [8:0]  addr_q;

  logic [tlv_pkg::PTR_W-1:0] off;
  logic [tlv_pkg::PTR_W-1:0] at;
  logic [tlv_pkg::PTR_W-1:0] ptr;
  logic [8:0]  size;
  logic [1:0]  sub;
  logic [7:0]  hdr [4];
  logic        scan_app;
  logic [31:0] crc_c;
  logic        allff;
  logic        pend;
  logic [2:0]  status_q;
  logic [31:0] vout_q;
  logic [31:0] crcres_q;

  logic                       ram_we;
  logic [tlv_pkg::ADDR_W-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic [tlv_pkg::ADDR_W-1:0] ram_raddr;
  logic [7:0]                 ram_rdata;

  tlv_ram #(
    .WIDTH(8),
    .DEPTH(tlv_pkg::PAYLOAD_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Decode the current request and the scanned header
  logic accept, out_free;
  logic is_word, is_get, is_set, is_remove, is_format;
  logic [15:0] hdr_key;
  logic [8:0] total;
  logic [tlv_pkg::SUM_W-1:0] off_end, need_end, mv_end;
  logic [3:0] need;
  logic over, stop, hit, blank, corrupt, type_ok, fail_space, trail_ok;
  logic [1:0] last_cnt;
  logic [tlv_pkg::SUM_W-1:0] bytes_sum;

  assign bytes_sum = tlv_pkg::SUM_W'(tlv_pkg::PAYLOAD_BYTES);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign is_word = (mode_q == tlv_pkg::MODE_GET_U32) || (mode_q == tlv_pkg::MODE_SET_U32);
  assign is_get = (mode_q == tlv_pkg::MODE_GET_U32) || (mode_q == tlv_pkg::MODE_GET_BOOL);
  assign is_set = (mode_q == tlv_pkg::MODE_SET_U32) || (mode_q == tlv_pkg::MODE_SET_BOOL);
  assign is_remove = (mode_q == tlv_pkg::MODE_REMOVE);
  assign is_format = (mode_q == tlv_pkg::MODE_FORMAT);
  assign hdr_key = {hdr[1], hdr[0]};
  assign total = 9'(tlv_pkg::HDR_LEN) + {1'b0, hdr[3]};
  assign off_end = {1'b0, off} + tlv_pkg::SUM_W'(total);
  assign over = ({1'b0, off} + tlv_pkg::SUM_W'(tlv_pkg::HDR_LEN)) > bytes_sum;
  assign stop = (hdr_key == end_key) || (hdr_key == tlv_pkg::BLANK_KEY) || (off_end > bytes_sum);
  assign hit = !stop && (hdr_key == key_q);
  assign blank = (hdr_key == tlv_pkg::BLANK_KEY);
  assign corrupt = !blank && (off_end > bytes_sum);
  assign type_ok = (hdr[2] == (is_word ? type_word : type_byte)) &&
                   (hdr[3] == (is_word ? 8'd4 : 8'd1));
  assign need = is_word ? 4'd8 : 4'd5;
  assign need_end = {1'b0, off} + tlv_pkg::SUM_W'(need);
  assign fail_space = need_end > bytes_sum;
  assign trail_ok = (need_end + tlv_pkg::SUM_W'(1)) < bytes_sum;
  assign last_cnt = is_word ? 2'd3 : 2'd0;
  assign mv_end = {1'b0, ptr} + tlv_pkg::SUM_W'(size);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tlv_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data.mode)
            tlv_pkg::MODE_GET_U32, tlv_pkg::MODE_GET_BOOL: state_next = tlv_pkg::S_SCAN_RD;
            tlv_pkg::MODE_SET_U32, tlv_pkg::MODE_SET_BOOL, tlv_pkg::MODE_REMOVE:
              state_next = valid_flag ? tlv_pkg::S_SCAN_RD : tlv_pkg::S_DONE;
            tlv_pkg::MODE_FORMAT: state_next = tlv_pkg::S_FILL;
            tlv_pkg::MODE_VERIFY: state_next = tlv_pkg::S_CRC;
            tlv_pkg::MODE_READ_BYTE: state_next = tlv_pkg::S_BYTE_RD;
            default: state_next = tlv_pkg::S_DONE;
          endcase
        end
      end
      tlv_pkg::S_SCAN_RD: begin
        if (!over) begin
          state_next = tlv_pkg::S_SCAN_CAP;
        end else if (scan_app) begin
          state_next = tlv_pkg::S_APP_END;
        end else if (is_get) begin
          state_next = tlv_pkg::S_DONE;
        end else if (is_set) begin
          state_next = tlv_pkg::S_SCAN_RD;
        end else begin
          state_next = tlv_pkg::S_CRC;
        end
      end
      tlv_pkg::S_SCAN_CAP: begin
        state_next = (sub == 2'd3) ? tlv_pkg::S_SCAN_EVAL : tlv_pkg::S_SCAN_RD;
      end
      tlv_pkg::S_SCAN_EVAL: begin
        if (scan_app) begin
          if (blank) state_next = tlv_pkg::S_APP_END;
          else if (corrupt) state_next = tlv_pkg::S_DONE;
          else state_next = tlv_pkg::S_SCAN_RD;
        end else if (stop) begin
          if (is_get) state_next = tlv_pkg::S_DONE;
          else if (is_set) state_next = tlv_pkg::S_SCAN_RD;
          else state_next = tlv_pkg::S_CRC;
        end else if (hit) begin
          if (is_get) state_next = type_ok ? tlv_pkg::S_DATA_RD : tlv_pkg::S_DONE;
          else state_next = tlv_pkg::S_MV_RD;
        end else begin
          state_next = tlv_pkg::S_SCAN_RD;
        end
      end
      tlv_pkg::S_APP_END: state_next = fail_space ? tlv_pkg::S_DONE : tlv_pkg::S_WR_REC;
      tlv_pkg::S_WR_REC: begin
        if (ptr == tlv_pkg::PTR_W'(need) + tlv_pkg::PTR_W'(1)) state_next = tlv_pkg::S_CRC;
      end
      tlv_pkg::S_DATA_RD: state_next = tlv_pkg::S_DATA_CAP;
      tlv_pkg::S_DATA_CAP: begin
        state_next = (sub == last_cnt) ? tlv_pkg::S_DONE : tlv_pkg::S_DATA_RD;
      end
      tlv_pkg::S_MV_RD: state_next = (mv_end >= bytes_sum) ? tlv_pkg::S_FILL : tlv_pkg::S_MV_WR;
      tlv_pkg::S_MV_WR: state_next = tlv_pkg::S_MV_RD;
      tlv_pkg::S_FILL: begin
        if (ptr == tlv_pkg::PTR_W'(tlv_pkg::PAYLOAD_BYTES - 1)) begin
          if (is_format) state_next = tlv_pkg::S_DONE;
          else if (is_remove) state_next = tlv_pkg::S_CRC;
          else state_next = tlv_pkg::S_SCAN_RD;
        end
      end
      tlv_pkg::S_CRC: begin
        if (ptr == tlv_pkg::PTR_W'(tlv_pkg::PAYLOAD_BYTES)) state_next = tlv_pkg::S_CRC_FIN;
      end
      tlv_pkg::S_CRC_FIN: state_next = tlv_pkg::S_DONE;
      tlv_pkg::S_BYTE_RD: state_next = tlv_pkg::S_BYTE_CAP;
      tlv_pkg::S_BYTE_CAP: state_next = tlv_pkg::S_DONE;
      tlv_pkg::S_DONE: if (out_free) state_next = tlv_pkg::S_IDLE;
      default: state_next = tlv_pkg::S_IDLE;
    endcase
  end

  // Memory port and handshake controls
  always_comb begin
    in_stall = (state != tlv_pkg::S_IDLE);
    ram_we = 1'b0;
    ram_waddr = ptr[tlv_pkg::ADDR_W-1:0];
    ram_wdata = tlv_pkg::ERASED_BYTE;
    ram_raddr = ptr[tlv_pkg::ADDR_W-1:0];
    case (state)
      tlv_pkg::S_IDLE: begin
        ram_we = accept && (in_data.mode == tlv_pkg::MODE_LOAD_BYTE);
        ram_waddr = in_data.address;
        ram_wdata = in_data.value[7:0];
      end
      tlv_pkg::S_SCAN_RD: ram_raddr = off[tlv_pkg::ADDR_W-1:0] + tlv_pkg::ADDR_W'(sub);
      tlv_pkg::S_DATA_RD: begin
        ram_raddr = at[tlv_pkg::ADDR_W-1:0] + tlv_pkg::ADDR_W'(tlv_pkg::HDR_LEN) +
                    tlv_pkg::ADDR_W'(sub);
      end
      tlv_pkg::S_MV_RD: ram_raddr = mv_end[tlv_pkg::ADDR_W-1:0];
      tlv_pkg::S_MV_WR: begin
        ram_we = 1'b1;
        ram_wdata = ram_rdata;
      end
      tlv_pkg::S_FILL: ram_we = 1'b1;
      tlv_pkg::S_WR_REC: begin
        ram_waddr = off[tlv_pkg::ADDR_W-1:0] + ptr[tlv_pkg::ADDR_W-1:0];
        ram_we = (ptr < tlv_pkg::PTR_W'(need)) || trail_ok;
        case (ptr[3:0])
          4'd0: ram_wdata = key_q[7:0];
          4'd1: ram_wdata = key_q[15:8];
          4'd2: ram_wdata = is_word ? type_word : type_byte;
          4'd3: ram_wdata = is_word ? 8'd4 : 8'd1;
          4'd4: ram_wdata = is_word ? value_q[7:0] : {7'd0, (value_q != 32'd0)};
          4'd5: ram_wdata = is_word ? value_q[15:8] : tlv_pkg::ERASED_BYTE;
          4'd6: ram_wdata = is_word ? value_q[23:16] : tlv_pkg::ERASED_BYTE;
          4'd7: ram_wdata = is_word ? value_q[31:24] : tlv_pkg::ERASED_BYTE;
          default: ram_wdata = tlv_pkg::ERASED_BYTE;
        endcase
      end
      tlv_pkg::S_BYTE_RD: ram_raddr = addr_q;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlv_pkg::S_IDLE;
      valid_flag <= 1'b0;
      out_valid <= 1'b0;
      end_key <= 16'd0;
      type_word <= 8'd2;
      type_byte <= 8'd1;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        case (cfg_index)
          tlv_pkg::CFG_END_KEY: end_key <= cfg_wr_data;
          tlv_pkg::CFG_TYPE_WORD: type_word <= cfg_wr_data[7:0];
          tlv_pkg::CFG_TYPE_BYTE: type_byte <= cfg_wr_data[7:0];
          default: ;
        endcase
      end
      if (state == tlv_pkg::S_FILL && is_format &&
          ptr == tlv_pkg::PTR_W'(tlv_pkg::PAYLOAD_BYTES - 1)) begin
        valid_flag <= 1'b1;
      end
      if (state == tlv_pkg::S_CRC_FIN && mode_q == tlv_pkg::MODE_VERIFY) begin
        valid_flag <= (value_q == 32'd0) || (~crc_c == value_q);
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == tlv_pkg::S_DONE && out_free) out_valid <= 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      tlv_pkg::S_IDLE: begin
        mode_q <= in_data.mode;
        key_q <= in_data.key;
        value_q <= in_data.value;
        addr_q <= in_data.address;
        off <= '0;
        sub <= '0;
        ptr <= '0;
        scan_app <= 1'b0;
        pend <= 1'b0;
        crc_c <= tlv_pkg::CRC_INIT;
        allff <= 1'b1;
        vout_q <= 32'd0;
        crcres_q <= 32'd0;
        status_q <= tlv_pkg::ST_OK;
        if (!valid_flag && (in_data.mode == tlv_pkg::MODE_SET_U32 ||
            in_data.mode == tlv_pkg::MODE_SET_BOOL || in_data.mode == tlv_pkg::MODE_REMOVE)) begin
          status_q <= tlv_pkg::ST_INVALID;
        end
      end
      tlv_pkg::S_SCAN_RD: begin
        if (over && !scan_app) begin
          if (is_get) status_q <= tlv_pkg::ST_NOT_FOUND;
          off <= '0;
          sub <= '0;
          scan_app <= is_set;
        end
      end
      tlv_pkg::S_SCAN_CAP: begin
        hdr[sub] <= ram_rdata;
        sub <= sub + 2'd1;
      end
      tlv_pkg::S_SCAN_EVAL: begin
        if (scan_app) begin
          if (corrupt) status_q <= tlv_pkg::ST_NO_SPACE;
          else if (!blank) off <= off_end[tlv_pkg::PTR_W-1:0];
        end else if (stop) begin
          if (is_get) status_q <= tlv_pkg::ST_NOT_FOUND;
          off <= '0;
          scan_app <= is_set;
        end else if (hit) begin
          at <= off;
          size <= total;
          ptr <= off;
          if (is_get && !type_ok) status_q <= tlv_pkg::ST_WRONG_TYPE;
        end else begin
          off <= off_end[tlv_pkg::PTR_W-1:0];
        end
      end
      tlv_pkg::S_APP_END: begin
        ptr <= '0;
        if (fail_space) status_q <= tlv_pkg::ST_NO_SPACE;
      end
      tlv_pkg::S_WR_REC: begin
        ptr <= (ptr == tlv_pkg::PTR_W'(need) + tlv_pkg::PTR_W'(1)) ? '0 : ptr + 1'b1;
      end
      tlv_pkg::S_DATA_CAP: begin
        if (is_word) vout_q[8*sub +: 8] <= ram_rdata;
        else vout_q <= {31'd0, (ram_rdata != 8'd0)};
        sub <= sub + 2'd1;
      end
      tlv_pkg::S_MV_RD: begin
        if (mv_end >= bytes_sum) begin
          ptr <= tlv_pkg::PTR_W'(bytes_sum - tlv_pkg::SUM_W'(size));
        end
      end
      tlv_pkg::S_MV_WR: ptr <= ptr + 1'b1;
      tlv_pkg::S_FILL: begin
        if (ptr == tlv_pkg::PTR_W'(tlv_pkg::PAYLOAD_BYTES - 1)) begin
          ptr <= '0;
          off <= '0;
          sub <= '0;
          scan_app <= 1'b1;
        end else begin
          ptr <= ptr + 1'b1;
        end
      end
      tlv_pkg::S_CRC: begin
        // Issue the next read while folding the byte read last cycle
        if (pend) begin
          crc_c <= tlv_pkg::crc_byte(crc_c, ram_rdata);
          allff <= allff && (ram_rdata == tlv_pkg::ERASED_BYTE);
        end
        pend <= (ptr != tlv_pkg::PTR_W'(tlv_pkg::PAYLOAD_BYTES));
        if (ptr != tlv_pkg::PTR_W'(tlv_pkg::PAYLOAD_BYTES)) ptr <= ptr + 1'b1;
      end
      tlv_pkg::S_CRC_FIN: begin
        if (mode_q == tlv_pkg::MODE_VERIFY) begin
          crcres_q <= ~crc_c;
          status_q <= ((value_q == 32'd0) || (~crc_c == value_q)) ?
                      tlv_pkg::ST_OK : tlv_pkg::ST_INVALID;
        end else begin
          crcres_q <= allff ? 32'd0 : ~crc_c;
        end
      end
      tlv_pkg::S_BYTE_CAP: vout_q <= {24'd0, ram_rdata};
      tlv_pkg::S_DONE: begin
        if (out_free) begin
          out_data.status <= status_q;
          out_data.value_out <= vout_q;
          out_data.crc_out <= crcres_q;
          out_data.store_valid <= valid_flag;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- src/tlv_ram.sv -----
module tlv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sim/tb_tlv_record_store_top.sv -----
module tb_tlv_record_store_top;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int HOLD_AT = 137;

  // Record store predictor and queue of pending results
  class tlv_scoreboard;
    logic [7:0]    mem [tlv_pkg::PAYLOAD_BYTES];
    bit            valid_flag;
    logic [15:0]   end_key;
    logic [7:0]    word_type;
    logic [7:0]    bool_type;
    tlv_pkg::rsp_t pending_q[$];
    int            errors;

    function new();
      valid_flag = 0;
      end_key = 16'h0000;
      word_type = 8'd2;
      bool_type = 8'd1;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] d);
      case (idx)
        tlv_pkg::CFG_END_KEY: end_key = d;
        tlv_pkg::CFG_TYPE_WORD: word_type = d[7:0];
        tlv_pkg::CFG_TYPE_BYTE: bool_type = d[7:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] key_at(int off);
      return {mem[off + 1], mem[off]};
    endfunction

    function logic [31:0] store_crc();
      logic [31:0] c;
      c = 32'hFFFFFFFF;
      for (int i = 0; i < tlv_pkg::PAYLOAD_BYTES; i++) begin
        c = c ^ {24'h0, mem[i]};
        for (int b = 0; b < 8; b++) c = (c >> 1) ^ (c[0] ? 32'hEDB88320 : 32'h0);
      end
      return ~c;
    endfunction

    function logic [31:0] seal_value();
      for (int i = 0; i < tlv_pkg::PAYLOAD_BYTES; i++)
        if (mem[i] != 8'hFF) return store_crc();
      return 32'h0;
    endfunction

    function bit find_rec(logic [15:0] k, output int at, output int sz);
      int off;
      int total;
      off = 0;
      at = 0;
      sz = 0;
      while (off + 4 <= tlv_pkg::PAYLOAD_BYTES) begin
        if (key_at(off) == end_key || key_at(off) == 16'hFFFF) return 0;
        total = 4 + mem[off + 3];
        if (off + total > tlv_pkg::PAYLOAD_BYTES) return 0;
        if (key_at(off) == k) begin
          at = off;
          sz = total;
          return 1;
        end
        off += total;
      end
      return 0;
    endfunction

    function void drop_rec(logic [15:0] k);
      int at;
      int sz;
      if (!find_rec(k, at, sz)) return;
      for (int i = at; i < tlv_pkg::PAYLOAD_BYTES - sz; i++) mem[i] = mem[i + sz];
      for (int i = tlv_pkg::PAYLOAD_BYTES - sz; i < tlv_pkg::PAYLOAD_BYTES; i++) mem[i] = 8'hFF;
    endfunction

    function bit append_rec(logic [15:0] k, logic [7:0] typ, logic [31:0] d, int len);
      int off;
      int total;
      off = 0;
      while (off + 4 <= tlv_pkg::PAYLOAD_BYTES) begin
        if (key_at(off) == 16'hFFFF) break;
        total = 4 + mem[off + 3];
        if (off + total > tlv_pkg::PAYLOAD_BYTES) return 0;
        off += total;
      end
      if (off + 4 + len > tlv_pkg::PAYLOAD_BYTES) return 0;
      mem[off] = k[7:0];
      mem[off + 1] = k[15:8];
      mem[off + 2] = typ;
      mem[off + 3] = len[7:0];
      for (int i = 0; i < len; i++) mem[off + 4 + i] = d[8*i +: 8];
      if (off + 4 + len + 1 < tlv_pkg::PAYLOAD_BYTES) begin
        mem[off + 4 + len] = 8'hFF;
        mem[off + 5 + len] = 8'hFF;
      end
      return 1;
    endfunction

    // Apply one accepted request and queue its result
    function void note_request(tlv_pkg::req_t r);
      tlv_pkg::rsp_t e;
      int   at;
      int   sz;
      bit   is_word;
      e = '0;
      case (r.mode)
        tlv_pkg::MODE_GET_U32, tlv_pkg::MODE_GET_BOOL: begin
          is_word = (r.mode == tlv_pkg::MODE_GET_U32);
          if (!find_rec(r.key, at, sz)) e.status = tlv_pkg::ST_NOT_FOUND;
          else if (mem[at + 2] != (is_word ? word_type : bool_type) ||
                   mem[at + 3] != (is_word ? 8'd4 : 8'd1)) e.status = tlv_pkg::ST_WRONG_TYPE;
          else if (is_word) e.value_out = {mem[at + 7], mem[at + 6], mem[at + 5], mem[at + 4]};
          else e.value_out = (mem[at + 4] != 0) ? 32'd1 : 32'd0;
        end
        tlv_pkg::MODE_SET_U32, tlv_pkg::MODE_SET_BOOL: begin
          if (!valid_flag) e.status = tlv_pkg::ST_INVALID;
          else begin
            drop_rec(r.key);
            if (!((r.mode == tlv_pkg::MODE_SET_U32) ?
                  append_rec(r.key, word_type, r.value, 4) :
                  append_rec(r.key, bool_type, {31'h0, r.value != 0}, 1)))
              e.status = tlv_pkg::ST_NO_SPACE;
            else e.crc_out = seal_value();
          end
        end
        tlv_pkg::MODE_REMOVE: begin
          if (!valid_flag) e.status = tlv_pkg::ST_INVALID;
          else begin
            drop_rec(r.key);
            e.crc_out = seal_value();
          end
        end
        tlv_pkg::MODE_FORMAT: begin
          for (int i = 0; i < tlv_pkg::PAYLOAD_BYTES; i++) mem[i] = 8'hFF;
          valid_flag = 1;
          e.crc_out = seal_value();
        end
        tlv_pkg::MODE_LOAD_BYTE: mem[r.address] = r.value[7:0];
        tlv_pkg::MODE_VERIFY: begin
          e.crc_out = store_crc();
          valid_flag = (r.value == 0) || (e.crc_out == r.value);
          e.status = valid_flag ? tlv_pkg::ST_OK : tlv_pkg::ST_INVALID;
        end
        tlv_pkg::MODE_READ_BYTE: e.value_out = {24'h0, mem[r.address]};
        default: ;
      endcase
      e.store_valid = valid_flag;
      pending_q.push_back(e);
    endfunction

    // Compare one delivered result with the oldest expectation
    function void check_result(tlv_pkg::rsp_t a);
      tlv_pkg::rsp_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: %p", a);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (a.status !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, a.status);
        errors++;
      end
      if (a.value_out !== e.value_out) begin
        $error("value_out: expected %h actual %h", e.value_out, a.value_out);
        errors++;
      end
      if (a.crc_out !== e.crc_out) begin
        $error("crc_out: expected %h actual %h", e.crc_out, a.crc_out);
        errors++;
      end
      if (a.store_valid !== e.store_valid) begin
        $error("store_valid: expected %0d actual %0d", e.store_valid, a.store_valid);
        errors++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  tlv_pkg::req_t in_data;
  logic          out_valid;
  logic          out_stall;
  tlv_pkg::rsp_t out_data;
  logic          cfg_wr_en;
  logic [1:0]    cfg_index;
  logic [15:0]   cfg_wr_data;

  tlv_scoreboard sb = new();
  int  idle_cycles = 0;
  int  burst_left = 0;
  int  sent_count = 0;

  tlv_record_store_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Check delivered results and stall on a pattern of our own
  always @(posedge clk) begin : receiver
    int stall_kind;
    int window;
    int hold_left;
    bit hold_done;
    if (out_valid && !out_stall) sb.check_result(out_data);
    if (window == 0) begin
      window = $urandom_range(20, 300);
      stall_kind = $urandom_range(0, 3);
    end
    window--;
    if (!hold_done && sent_count == HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1;
    end
    if (rst) begin
      out_stall <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      case (stall_kind)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 99) < 80);
      endcase
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL tlv_record_store_top");
      $finish;
    end
  end

  // Offer one request, with bursts and gaps, and hold it until taken
  task automatic send_req(tlv_pkg::req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] d);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.set_reg(idx, d);
  endtask

  function automatic tlv_pkg::req_t make_req(logic [3:0] m, logic [15:0] k, logic [31:0] v,
                                             logic [8:0] a);
    tlv_pkg::req_t r;
    r.mode = m;
    r.key = k;
    r.value = v;
    r.address = a;
    return r;
  endfunction

  // Random request: mostly record traffic on a small key pool
  function automatic tlv_pkg::req_t random_req();
    tlv_pkg::req_t r;
    int   pick;
    r.key = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 70));
    r.value = ($urandom_range(0, 5) == 0) ? 32'h0 : $urandom();
    r.address = 9'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 20) r.mode = tlv_pkg::MODE_SET_U32;
    else if (pick < 32) r.mode = tlv_pkg::MODE_SET_BOOL;
    else if (pick < 47) r.mode = tlv_pkg::MODE_GET_U32;
    else if (pick < 57) r.mode = tlv_pkg::MODE_GET_BOOL;
    else if (pick < 66) r.mode = tlv_pkg::MODE_REMOVE;
    else if (pick < 74) r.mode = tlv_pkg::MODE_READ_BYTE;
    else if (pick < 81) r.mode = tlv_pkg::MODE_LOAD_BYTE;
    else if (pick < 92) begin
      r.mode = tlv_pkg::MODE_VERIFY;
      if ($urandom_range(0, 1) == 0) r.value = sb.store_crc();
    end else if (pick < 94) r.mode = tlv_pkg::MODE_FORMAT;
    else if (pick < 97) r.mode = 4'($urandom_range(9, 15));
    else r.mode = 4'($urandom());
    return r;
  endfunction

  initial begin
    logic [15:0] end_keys [5];
    logic [7:0]  word_codes [5];
    logic [7:0]  bool_codes [5];
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_wr_en = 0;
    cfg_index = tlv_pkg::CFG_END_KEY;
    cfg_wr_data = 16'h0;
    end_keys = '{16'h0000, 16'hFFFF, 16'h0005, 16'($urandom()), 16'h0000};
    word_codes = '{8'd2, 8'hFF, 8'h00, 8'd7, 8'd2};
    bool_codes = '{8'd1, 8'h00, 8'hFF, 8'd7, 8'd1};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: format first so nothing unwritten is ever read
    send_req(make_req(tlv_pkg::MODE_FORMAT, 16'h0, 32'h0, 9'h0));
    send_req(make_req(tlv_pkg::MODE_VERIFY, 16'h0, 32'h0, 9'h0));
    send_req(make_req(tlv_pkg::MODE_GET_U32, 16'h0001, 32'h0, 9'h0));
    send_req(make_req(tlv_pkg::MODE_SET_U32, 16'h0001, 32'hFFFFFFFF, 9'h0));
    send_req(make_req(tlv_pkg::MODE_SET_U32, 16'h0002, 32'h0, 9'h0));
    send_req(make_req(tlv_pkg::MODE_SET_BOOL, 16'h0003, 32'h0, 9'h0));
    send_req(make_req(tlv_pkg::MODE_SET_BOOL, 16'hFFFE, 32'h80000000, 9'h0));
    send_req(make_req(tlv_pkg::MODE_GET_U32, 16'h0001, 32'h0, 9'h0));
    send_req(make_req(tlv_pkg::MODE_GET_BOOL, 16'hFFFE, 32'h0, 9'h0));
    send_req(make_req(tlv_pkg::MODE_GET_BOOL, 16'h0001, 32'h0, 9'h0));
    send_req(make_req(tlv_pkg::MODE_GET_U32, 16'h0003, 32'h0, 9'h0));
    send_req(make_req(tlv_pkg::MODE_SET_U32, 16'h0001, 32'h12345678, 9'h0));
    send_req(make_req(tlv_pkg::MODE_REMOVE, 16'h0002, 32'h0, 9'h0));
    send_req(make_req(tlv_pkg::MODE_REMOVE, 16'h0063, 32'h0, 9'h0));
    send_req(make_req(tlv_pkg::MODE_READ_BYTE, 16'h0, 32'h0, 9'h000));
    send_req(make_req(tlv_pkg::MODE_READ_BYTE, 16'h0, 32'h0, 9'h1FF));
    send_req(make_req(tlv_pkg::MODE_LOAD_BYTE, 16'h0, 32'hFFFFFFAB, 9'h1FF));
    send_req(make_req(tlv_pkg::MODE_VERIFY, 16'h0, 32'hFFFFFFFF, 9'h0));
    send_req(make_req(tlv_pkg::MODE_SET_U32, 16'h0004, 32'h1, 9'h0));
    send_req(make_req(tlv_pkg::MODE_REMOVE, 16'h0001, 32'h0, 9'h0));
    send_req(make_req(tlv_pkg::MODE_GET_U32, 16'h0001, 32'h0, 9'h0));
    send_req(make_req(tlv_pkg::MODE_VERIFY, 16'h0, sb.store_crc(), 9'h0));
    send_req(make_req(4'd9, 16'hFFFF, 32'hFFFFFFFF, 9'h1FF));
    send_req(make_req(4'd15, 16'h0, 32'h0, 9'h0));

    // Random phases under a range of register settings
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(tlv_pkg::CFG_END_KEY, end_keys[p]);
      write_reg(tlv_pkg::CFG_TYPE_WORD, {8'h0, word_codes[p]});
      write_reg(tlv_pkg::CFG_TYPE_BYTE, {8'h0, bool_codes[p]});
      @(posedge clk);
      for (int n = 0; n < 103; n++) begin
        send_req(random_req());
      end
    end

    // Wait out every pending result, then a short tail
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("PASS tlv_record_store_top");
    else $display("FAIL tlv_record_store_top");
    $finish;
  end

endmodule
